// ===== rtl/salru_pkg.sv =====
// Package for the set-associative LRU cache tracker: shared constants, types and codes.
// No dependencies; used by salru_front, salru_back and the top level (salru_ram does not use it).
package salru_pkg;

  localparam int MaxSetBitsDefault = 6;
  localparam int WaysDefault       = 4;
  localparam int AddrWidthDefault  = 64;
  localparam int CntWidth          = 32;

  localparam logic [1:0] ModeLoad   = 2'd0;
  localparam logic [1:0] ModeStore  = 2'd1;
  localparam logic [1:0] ModeModify = 2'd2;

  localparam logic [1:0] OutHit   = 2'd0;
  localparam logic [1:0] OutMiss  = 2'd1;
  localparam logic [1:0] OutEvict = 2'd2;

  localparam logic [1:0] RegSetBits   = 2'd0;
  localparam logic [1:0] RegBlockBits = 2'd1;
  localparam logic [1:0] RegWaysInUse = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_WRITE,
    ST_OUT
  } eng_state_t;

endpackage

// ===== rtl/salru_front.sv =====
// Front end: accepts words, splits the address into set index and tag, pushes into a queue.
// Depends on salru_pkg.
module salru_front #(
  parameter int MAX_SET_BITS = salru_pkg::MaxSetBitsDefault,
  parameter int ADDR_WIDTH   = salru_pkg::AddrWidthDefault,
  parameter int IDX_W        = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_mode,
  input  logic [63:0]           in_address,
  input  logic [2:0]            set_bits,
  input  logic [5:0]            offset_bits,
  output logic                  q_valid,
  input  logic                  q_pop,
  output logic                  q_modify,
  output logic [IDX_W-1:0]      q_index,
  output logic [ADDR_WIDTH-1:0] q_tag
);

  localparam int EntW = 1 + IDX_W + ADDR_WIDTH;

  logic [EntW-1:0] ent [2];
  logic [1:0]      cnt;
  logic            wr_ptr;
  logic            rd_ptr;
  logic [EntW-1:0] ent_in;
  logic [ADDR_WIDTH-1:0] a;
  logic [ADDR_WIDTH-1:0] shifted;
  logic [ADDR_WIDTH-1:0] tag;
  logic [IDX_W-1:0]      idx;
  logic [3:0]            s_eff;
  logic [6:0]            tsh;
  logic                  push;

  always_comb begin
    a = in_address[ADDR_WIDTH-1:0];
    if (32'(set_bits) > MAX_SET_BITS) begin
      s_eff = 4'(MAX_SET_BITS);
    end else begin
      s_eff = {1'b0, set_bits};
    end
    shifted = a >> offset_bits;
    idx = IDX_W'(shifted) & IDX_W'((({{(IDX_W+1){1'b0}}} | 1) << s_eff) - 1);
    if (MAX_SET_BITS == 0) begin
      idx = '0;
    end
    tsh = 7'(offset_bits) + 7'(s_eff);
    if (tsh >= 7'd64) begin
      tag = '0;
    end else begin
      tag = a >> tsh;
    end
    ent_in = {in_mode == salru_pkg::ModeModify, idx, tag};
  end

  assign in_ready = (cnt != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt != 2'd0);
  assign {q_modify, q_index, q_tag} = ent[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= '0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      cnt <= cnt + 2'(push) - 2'(q_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent[wr_ptr] <= ent_in;
    end
  end

endmodule

// ===== rtl/salru_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module salru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/salru_back.sv =====
// Back end: reads a set, picks hit / fill / victim, writes the set back, updates totals.
// Depends on salru_pkg and salru_ram.
module salru_back #(
  parameter int MAX_SET_BITS = salru_pkg::MaxSetBitsDefault,
  parameter int WAYS         = salru_pkg::WaysDefault,
  parameter int ADDR_WIDTH   = salru_pkg::AddrWidthDefault,
  parameter int IDX_W        = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [2:0]            ways_in_use,
  input  logic                  q_valid,
  output logic                  q_pop,
  input  logic                  q_modify,
  input  logic [IDX_W-1:0]      q_index,
  input  logic [ADDR_WIDTH-1:0] q_tag,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            first_outcome,
  output logic [1:0]            second_outcome,
  output logic [31:0]           total_hits,
  output logic [31:0]           total_misses,
  output logic [31:0]           total_evictions
);

  localparam int NSETS = 1 << MAX_SET_BITS;
  localparam int WW    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int AGEW  = WW;
  localparam int NW    = $clog2(WAYS + 1);
  localparam logic [31:0] CntMax = '1;

  salru_pkg::eng_state_t state, state_next;

  logic [NSETS-1:0][WAYS-1:0]           valid;
  logic [ADDR_WIDTH-1:0] rd_tag [WAYS];
  logic [WAYS-1:0]       tag_we;
  logic                  second;
  logic                  modify;
  logic [IDX_W-1:0]      idx;
  logic [ADDR_WIDTH-1:0] tag;
  logic [NW-1:0]         n;
  logic [WW-1:0]         sel_w;
  logic [1:0]            res;
  logic [WW-1:0]         sel_w_r;
  logic [1:0]            res_r;
  logic [WAYS-1:0]       vrow;
  logic [WAYS-1:0]       vrow_r;
  logic [WAYS-1:0][AGEW-1:0] arow;
  logic [WAYS-1:0][AGEW-1:0] rd_age;
  logic [WAYS-1:0][AGEW-1:0] age_r;
  logic [WAYS-1:0][AGEW-1:0] age_wdata;
  logic                  age_we;
  logic                  found_hit, found_inv, found_old;
  logic [WW-1:0]         hit_w, inv_w, old_w;
  logic [AGEW-1:0]       old_age;
  logic [NW-1:0]         prev;

  always_comb begin
    if (ways_in_use == 3'd0) begin
      n = NW'(1);
    end else if (32'(ways_in_use) > WAYS) begin
      n = NW'(WAYS);
    end else begin
      n = NW'(ways_in_use);
    end
  end

  for (genvar g = 0; g < WAYS; g++) begin : g_tag
    salru_ram #(.WIDTH(ADDR_WIDTH), .DEPTH(NSETS)) u_tag (
      .clk  (clk),
      .we   (tag_we[g]),
      .waddr(idx),
      .wdata(tag),
      .raddr(q_index),
      .rdata(rd_tag[g])
    );
  end

  // age ranks of a set; only read for valid lines, so no clear is needed
  salru_ram #(.WIDTH(WAYS * AGEW), .DEPTH(NSETS)) u_age (
    .clk  (clk),
    .we   (age_we),
    .waddr(idx),
    .wdata(age_wdata),
    .raddr(q_index),
    .rdata(rd_age)
  );

  // classify the set read in ST_LOOK
  always_comb begin
    vrow = vrow_r;
    arow = rd_age;
    found_hit = 1'b0; found_inv = 1'b0; found_old = 1'b0;
    hit_w = '0; inv_w = '0; old_w = '0; old_age = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (w < 32'(n)) begin
        if (vrow[w]) begin
          if (!found_hit && rd_tag[w] == tag) begin
            found_hit = 1'b1; hit_w = WW'(w);
          end
          if (!found_old || arow[w] > old_age) begin
            found_old = 1'b1; old_w = WW'(w); old_age = arow[w];
          end
        end else if (!found_inv) begin
          found_inv = 1'b1; inv_w = WW'(w);
        end
      end
    end
    if (found_hit) begin
      sel_w = hit_w; res = salru_pkg::OutHit;
    end else if (found_inv) begin
      sel_w = inv_w; res = salru_pkg::OutMiss;
    end else begin
      sel_w = old_w; res = salru_pkg::OutEvict;
    end
    // second pass of a modify always hits the line the first pass touched
    if (second) begin
      sel_w = sel_w_r; res = salru_pkg::OutHit;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      salru_pkg::ST_IDLE:  if (q_valid) state_next = salru_pkg::ST_LOOK;
      salru_pkg::ST_LOOK:  state_next = salru_pkg::ST_WRITE;
      salru_pkg::ST_WRITE: state_next = (modify && !second) ? salru_pkg::ST_LOOK
                                                            : salru_pkg::ST_OUT;
      salru_pkg::ST_OUT:   if (out_ready) state_next = salru_pkg::ST_IDLE;
      default:             state_next = salru_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = (state == salru_pkg::ST_IDLE) && q_valid;
    out_valid = (state == salru_pkg::ST_OUT);
    tag_we    = '0;
    age_we    = (state == salru_pkg::ST_WRITE) && !second;
    if (state == salru_pkg::ST_WRITE && !second && res_r != salru_pkg::OutHit) begin
      tag_we[sel_w_r] = 1'b1;
    end
  end

  assign prev = (res_r == salru_pkg::OutMiss) ? n : NW'(age_r[sel_w_r]);

  // age every younger in-use line by one, capped at the oldest rank
  always_comb begin
    age_wdata = age_r;
    for (int k = 0; k < WAYS; k++) begin
      if (k < 32'(n) && WW'(k) != sel_w_r && vrow_r[k]
          && NW'(age_r[k]) < prev && NW'(age_r[k]) < n - NW'(1)) begin
        age_wdata[k] = age_r[k] + AGEW'(1);
      end
    end
    age_wdata[sel_w_r] = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= salru_pkg::ST_IDLE;
      valid           <= '0;
      total_hits      <= '0;
      total_misses    <= '0;
      total_evictions <= '0;
    end else begin
      state <= state_next;
      if (state == salru_pkg::ST_LOOK) begin
        if (res == salru_pkg::OutHit) begin
          if (total_hits != CntMax) total_hits <= total_hits + 32'd1;
        end else begin
          if (total_misses != CntMax) total_misses <= total_misses + 32'd1;
          if (res == salru_pkg::OutEvict && total_evictions != CntMax) begin
            total_evictions <= total_evictions + 32'd1;
          end
        end
      end
      if (state == salru_pkg::ST_WRITE) begin
        valid[idx][sel_w_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == salru_pkg::ST_IDLE && q_valid) begin
      idx    <= q_index;
      tag    <= q_tag;
      modify <= q_modify;
      vrow_r <= valid[q_index];
      second <= 1'b0;
      second_outcome <= 2'd0;
    end
    if (state == salru_pkg::ST_LOOK) begin
      sel_w_r <= sel_w;
      res_r   <= res;
      if (second) begin
        second_outcome <= res + 2'd1;
      end else begin
        first_outcome <= res;
        age_r         <= rd_age;
      end
    end
    if (state == salru_pkg::ST_WRITE) begin
      second <= 1'b1;
    end
  end

`ifndef SYNTHESIS
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(first_outcome))
    else $error("result changed while stalled");
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> state == salru_pkg::ST_LOOK)
    else $error("pop without lookup");
  a_hits_mono: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> total_hits >= $past(total_hits))
    else $error("hit total went down");
`endif

endmodule

// ===== rtl/set_assoc_lru_cache_tracker.sv =====
// Set-associative LRU cache tracker, top level: config registers, front end, back end.
// Depends on salru_pkg, salru_front, salru_back, salru_ram.
// A word passes pop (ST_IDLE), set read (ST_LOOK), write-back (ST_WRITE) and result hand-off
// (ST_OUT, held while out_ready is low); a modify runs the read and write-back twice.
// The back end pops the next word only after the result of the last one has been taken.
// A two-entry queue lets the front accept while the back works or its result waits.
// Reset (rst, synchronous): valid bits clear, totals zero, registers to their defaults.
module set_assoc_lru_cache_tracker #(
  parameter int MAX_SET_BITS = salru_pkg::MaxSetBitsDefault,
  parameter int WAYS         = salru_pkg::WaysDefault,
  parameter int ADDR_WIDTH   = salru_pkg::AddrWidthDefault
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [71:0]  s_axis_tdata,   // mode[1:0], address[65:2], zero pad
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [103:0] m_axis_tdata,   // first_outcome, second_outcome, hits, misses, evictions
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [5:0]   cfg_data
);

  localparam int IDX_W = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;

  logic [2:0] set_bits;
  logic [5:0] offset_bits;
  logic [2:0] ways_in_use;

  logic                  q_valid;
  logic                  q_pop;
  logic                  q_modify;
  logic [IDX_W-1:0]      q_index;
  logic [ADDR_WIDTH-1:0] q_tag;
  logic [1:0]            first_outcome;
  logic [1:0]            second_outcome;
  logic [31:0]           total_hits;
  logic [31:0]           total_misses;
  logic [31:0]           total_evictions;

  // config registers; unknown indexes drop the write
  always_ff @(posedge clk) begin
    if (rst) begin
      set_bits    <= 3'd0;
      offset_bits <= 6'd0;
      ways_in_use <= 3'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        salru_pkg::RegSetBits:   set_bits    <= cfg_data[2:0];
        salru_pkg::RegBlockBits: offset_bits <= cfg_data;
        salru_pkg::RegWaysInUse: ways_in_use <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  salru_front #(.MAX_SET_BITS(MAX_SET_BITS), .ADDR_WIDTH(ADDR_WIDTH)) u_front (
    .clk(clk), .rst(rst),
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_mode(s_axis_tdata[1:0]), .in_address(s_axis_tdata[65:2]),
    .set_bits(set_bits), .offset_bits(offset_bits),
    .q_valid(q_valid), .q_pop(q_pop), .q_modify(q_modify),
    .q_index(q_index), .q_tag(q_tag)
  );

  salru_back #(.MAX_SET_BITS(MAX_SET_BITS), .WAYS(WAYS), .ADDR_WIDTH(ADDR_WIDTH)) u_back (
    .clk(clk), .rst(rst), .ways_in_use(ways_in_use),
    .q_valid(q_valid), .q_pop(q_pop), .q_modify(q_modify),
    .q_index(q_index), .q_tag(q_tag),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .first_outcome(first_outcome), .second_outcome(second_outcome),
    .total_hits(total_hits), .total_misses(total_misses),
    .total_evictions(total_evictions)
  );

  assign m_axis_tdata = {4'd0, total_evictions, total_misses, total_hits,
                         second_outcome, first_outcome};

endmodule

// ===== sim/tb_set_assoc_lru_cache_tracker.sv =====
// Self-checking bench for the set-associative LRU cache tracker top level.
// Depends on salru_pkg and the RTL under rtl; predicts each result word in-bench.
module tb_set_assoc_lru_cache_tracker;

  localparam int NumSets   = 1 << salru_pkg::MaxSetBitsDefault;
  localparam int NumWays   = salru_pkg::WaysDefault;
  localparam int IdleLimit = 20000;
  localparam int Drain     = 12;
  localparam logic [1:0] RegUnused = 2'd3;

  typedef struct packed {
    logic [1:0]  first;
    logic [1:0]  second;
    logic [31:0] hits;
    logic [31:0] misses;
    logic [31:0] evicts;
  } outcome_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [71:0]  s_axis_tdata = '0;   // mode[1:0], address[65:2], zero pad
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [103:0] m_axis_tdata;        // first[1:0], second[3:2], hits, misses, evictions
  logic         cfg_we = 1'b0;
  logic [1:0]   cfg_index = '0;
  logic [5:0]   cfg_data = '0;

  // Shadow of the cache contents and the register file.
  logic        shadow_valid [NumSets][NumWays];
  logic [63:0] shadow_tag   [NumSets][NumWays];
  int unsigned shadow_age   [NumSets][NumWays];
  logic [31:0] hit_count, miss_count, evict_count;
  logic [2:0]  reg_set_bits;
  logic [5:0]  reg_offset_bits;
  logic [2:0]  reg_ways;

  outcome_t pending_q[$];
  int       errors = 0;
  int       idle_cycles = 0;
  int       stall_left = 0;

  set_assoc_lru_cache_tracker uut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  function automatic logic [31:0] sat_inc(logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function automatic int unsigned pick_gap();
    // Mostly back-to-back or short, now and then a long pause.
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // One tag lookup with LRU update; returns hit, miss or miss with eviction.
  function automatic logic [1:0] lookup_line(logic [63:0] addr);
    int unsigned s, n, idx, w, hit_w, inv_w, old_w, old_age, prev;
    logic [63:0] tag;
    logic [1:0]  res;
    s = (reg_set_bits > salru_pkg::MaxSetBitsDefault) ? salru_pkg::MaxSetBitsDefault
                                                       : reg_set_bits;
    n = (reg_ways < 1) ? 1 : (reg_ways > NumWays) ? NumWays : reg_ways;
    idx = int'((addr >> reg_offset_bits) & ((64'd1 << s) - 64'd1));
    tag = (reg_offset_bits + s >= 64) ? 64'd0 : (addr >> (reg_offset_bits + s));
    hit_w = NumWays; inv_w = NumWays; old_w = NumWays; old_age = 0;
    for (int k = 0; k < n; k++) begin
      if (shadow_valid[idx][k]) begin
        if (hit_w == NumWays && shadow_tag[idx][k] == tag) hit_w = k;
        if (old_w == NumWays || shadow_age[idx][k] > old_age) begin
          old_w = k;
          old_age = shadow_age[idx][k];
        end
      end else if (inv_w == NumWays) begin
        inv_w = k;
      end
    end
    if (hit_w != NumWays) begin
      hit_count = sat_inc(hit_count);
      w = hit_w; prev = shadow_age[idx][w]; res = salru_pkg::OutHit;
    end else if (inv_w != NumWays) begin
      miss_count = sat_inc(miss_count);
      w = inv_w; prev = n; res = salru_pkg::OutMiss;
      shadow_valid[idx][w] = 1'b1;
      shadow_tag[idx][w] = tag;
    end else begin
      miss_count = sat_inc(miss_count);
      evict_count = sat_inc(evict_count);
      w = old_w; prev = shadow_age[idx][w]; res = salru_pkg::OutEvict;
      shadow_tag[idx][w] = tag;
    end
    // Age every younger in-use line by one, capped at the oldest rank.
    for (int k = 0; k < n; k++)
      if (k != w && shadow_valid[idx][k] && shadow_age[idx][k] < prev
          && shadow_age[idx][k] < n - 1)
        shadow_age[idx][k]++;
    shadow_age[idx][w] = 0;
    return res;
  endfunction

  function automatic outcome_t predict_access(logic [1:0] mode, logic [63:0] addr);
    outcome_t o;
    o.first = lookup_line(addr);
    o.second = (mode == salru_pkg::ModeModify) ? lookup_line(addr) + 2'd1 : 2'd0;
    o.hits = hit_count;
    o.misses = miss_count;
    o.evicts = evict_count;
    return o;
  endfunction

  // Present one word; hold it until the block takes it, then queue its prediction.
  task automatic send_access(logic [1:0] mode, logic [63:0] addr);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'd0, addr, mode};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pending_q.push_back(predict_access(mode, addr));
  endtask

  // Drop valid and wait out every outstanding result plus the pipeline tail.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_q.size() != 0) @(posedge clk);
    repeat (Drain) @(posedge clk);
  endtask

  // Pulse the write enable for one cycle and mirror the write in the shadow registers.
  task automatic write_reg(logic [1:0] index, logic [5:0] value);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (index)
      salru_pkg::RegSetBits:   reg_set_bits = value[2:0];
      salru_pkg::RegBlockBits: reg_offset_bits = value;
      salru_pkg::RegWaysInUse: reg_ways = value[2:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic configure(logic [5:0] sb, logic [5:0] bb, logic [5:0] wy);
    wait_idle();
    write_reg(salru_pkg::RegSetBits, sb);
    write_reg(salru_pkg::RegBlockBits, bb);
    write_reg(salru_pkg::RegWaysInUse, wy);
  endtask

  // Addresses from a small pool of tags per set so that sets fill and evict.
  function automatic logic [63:0] pool_address();
    int unsigned s;
    logic [63:0] a;
    s = (reg_set_bits > salru_pkg::MaxSetBitsDefault) ? salru_pkg::MaxSetBitsDefault
                                                       : reg_set_bits;
    if ($urandom_range(0, 9) == 0) return {$urandom, $urandom};
    a = 64'($urandom_range(0, 5)) << (reg_offset_bits + s);
    a |= (64'($urandom_range(0, 3)) << reg_offset_bits)
         & (((64'd1 << s) - 1) << reg_offset_bits);
    a |= {$urandom, $urandom} & ((64'd1 << reg_offset_bits) - 1);
    return a;
  endfunction

  task automatic test_directed();
    // Default registers: one set, one way, byte granularity.
    send_access(salru_pkg::ModeLoad, 64'd0);
    send_access(salru_pkg::ModeLoad, 64'd0);
    send_access(salru_pkg::ModeStore, 64'hFFFF_FFFF_FFFF_FFFF);
    send_access(salru_pkg::ModeModify, 64'h1234);
    send_access(salru_pkg::ModeModify, 64'h1234);
    send_access(2'd3, 64'h8000_0000_0000_0000);   // unused mode acts as a load
    // Four ways, two sets: fill set 0, evict the oldest, hit, then evict again with a modify.
    configure(6'd1, 6'd4, 6'd4);
    for (int i = 0; i < 5; i++) send_access(salru_pkg::ModeLoad, 64'(i) << 5);
    send_access(salru_pkg::ModeLoad, 64'h20);
    send_access(salru_pkg::ModeModify, 64'h1000);
    // Shrink ways with four valid lines left behind, then grow back.
    configure(6'd1, 6'd4, 6'd2);
    send_access(salru_pkg::ModeLoad, 64'h40);
    send_access(salru_pkg::ModeStore, 64'h60);
    configure(6'd1, 6'd4, 6'd4);
    send_access(salru_pkg::ModeLoad, 64'h60);
    // Out-of-range settings: set bits saturate, ways clamp, tag goes to zero.
    configure(6'd7, 6'd63, 6'd0);
    send_access(salru_pkg::ModeLoad, 64'hFFFF_FFFF_FFFF_FFFF);
    send_access(salru_pkg::ModeLoad, 64'h7FFF_FFFF_FFFF_FFFF);
    configure(6'd6, 6'd58, 6'd7);
    send_access(salru_pkg::ModeModify, 64'hFFFF_FFFF_FFFF_FFFF);
    send_access(salru_pkg::ModeLoad, 64'h0400_0000_0000_0000);
    // Write to the unused index must change nothing.
    wait_idle();
    write_reg(RegUnused, 6'h3F);
    send_access(salru_pkg::ModeLoad, 64'h0);
  endtask

  task automatic run_random_phase(logic [5:0] sb, logic [5:0] bb, logic [5:0] wy,
                                  int unsigned count);
    configure(sb, bb, wy);
    for (int i = 0; i < count; i++)
      send_access(2'($urandom_range(0, 3)), pool_address());
  endtask

  task automatic test_random();
    run_random_phase(6'd0, 6'd0, 6'd1, 60);
    run_random_phase(6'd2, 6'd3, 6'd4, 140);
    run_random_phase(6'd6, 6'd6, 6'd3, 140);
    run_random_phase(6'd7, 6'd63, 6'd7, 60);
    run_random_phase(6'd1, 6'd20, 6'd2, 120);
    run_random_phase(6'd4, 6'd32, 6'd0, 100);
    run_random_phase(6'd3, 6'd1, 6'd4, 180);
  endtask

  // Result side: random back-pressure, compare each word with the oldest prediction.
  always @(posedge clk) begin
    outcome_t exp_o, got_o;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        m_axis_tready <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        stall_left <= pick_gap();
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (m_axis_tvalid && m_axis_tready) begin
        got_o = {m_axis_tdata[1:0], m_axis_tdata[3:2], m_axis_tdata[35:4],
                 m_axis_tdata[67:36], m_axis_tdata[99:68]};
        if (pending_q.size() == 0) begin
          $display("%0t: unexpected result word %h", $time, m_axis_tdata);
          errors++;
        end else begin
          exp_o = pending_q.pop_front();
          if (got_o.first !== exp_o.first) begin
            $display("%0t: first_outcome exp %0d got %0d", $time, exp_o.first, got_o.first);
            errors++;
          end
          if (got_o.second !== exp_o.second) begin
            $display("%0t: second_outcome exp %0d got %0d", $time, exp_o.second,
                     got_o.second);
            errors++;
          end
          if (got_o.hits !== exp_o.hits) begin
            $display("%0t: total_hits exp %0d got %0d", $time, exp_o.hits, got_o.hits);
            errors++;
          end
          if (got_o.misses !== exp_o.misses) begin
            $display("%0t: total_misses exp %0d got %0d", $time, exp_o.misses,
                     got_o.misses);
            errors++;
          end
          if (got_o.evicts !== exp_o.evicts) begin
            $display("%0t: total_evictions exp %0d got %0d", $time, exp_o.evicts,
                     got_o.evicts);
            errors++;
          end
        end
      end
    end
  end

  // Watchdog: end the run if nothing moves for too long.
  always @(posedge clk) begin
    if (idle_cycles >= IdleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    for (int s = 0; s < NumSets; s++)
      for (int w = 0; w < NumWays; w++) begin
        shadow_valid[s][w] = 1'b0;
        shadow_tag[s][w] = '0;
        shadow_age[s][w] = 0;
      end
    hit_count = '0; miss_count = '0; evict_count = '0;
    reg_set_bits = '0; reg_offset_bits = '0; reg_ways = 3'd1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random();
    wait_idle();
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
